// ----- src/spaced_repetition_card_update_defines.svh -----
// Assertion macros shared by the card update modules.
`ifndef SPACED_REPETITION_CARD_UPDATE_DEFINES_SVH
`define SPACED_REPETITION_CARD_UPDATE_DEFINES_SVH

// Checks an implication that must hold at every clock edge out of reset.
`define SRCU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks an implication whose consequence is due at the next clock edge.
`define SRCU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/srcu_pkg.sv -----
package srcu_pkg;

    localparam logic [1:0] STATUS_RATED   = 2'd0;
    localparam logic [1:0] STATUS_SESSION = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [1:0] RATE_AGAIN = 2'd0;
    localparam logic [1:0] RATE_HARD  = 2'd1;
    localparam logic [1:0] RATE_GOOD  = 2'd2;
    localparam logic [1:0] RATE_EASY  = 2'd3;

    localparam logic [11:0] EASE_INIT = 12'd2500;
    localparam logic [11:0] EASE_MIN  = 12'd1300;
    localparam logic [11:0] EASE_MAX  = 12'd3500;

    // Reciprocals for the divides by 1000 and 10000. The quotient is the
    // product shifted right by 38 and by 45 bits; both are exact for any
    // 32-bit dividend.
    localparam logic [31:0] RECIP_1000  = 32'h1062_4DD3;
    localparam logic [31:0] RECIP_10000 = 32'hD1B7_1759;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_READ_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Per-entry record held in the table.
    typedef struct packed {
        logic [11:0] ease;
        logic [15:0] interval;
        logic [15:0] due;
        logic [15:0] reviews;
        logic [15:0] lapses;
        logic [15:0] again;
        logic [15:0] hard;
        logic [15:0] good;
        logic [15:0] easy;
        logic [17:0] last_seen;
    } record_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ----- src/srcu_key_cell.sv -----
// One cell of the search chain. A probe (key, index) marches right one
// cell a cycle; each cell holds a slice of the key table and compares the
// probe against the entry stored in its slice.
module srcu_key_cell #(
    parameter int SLICE   = 32,
    parameter int IDX_W   = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [31:0]       in_key,
    input  logic [IDX_W-1:0]  in_pos,
    input  logic              in_hit,
    input  logic [IDX_W-1:0]  in_hit_idx,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [31:0]       wr_key,
    input  logic [IDX_W-1:0]  base,
    output logic              out_valid,
    output logic [31:0]       out_key,
    output logic [IDX_W-1:0]  out_pos,
    output logic              out_hit,
    output logic [IDX_W-1:0]  out_hit_idx
);
    localparam int SW = (SLICE > 1) ? $clog2(SLICE) : 1;

    logic [31:0] mem [SLICE];
    logic [31:0] rd_reg;
    logic        valid_reg;
    logic [31:0] key_reg;
    logic [IDX_W-1:0] pos_reg;
    logic        hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] off;
    logic [IDX_W-1:0] woff;

    assign off  = in_pos - base;
    assign woff = wr_idx - base;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[woff[SW-1:0]] <= wr_key;
        end
        rd_reg <= mem[off[SW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        key_reg     <= in_key;
        pos_reg     <= in_pos;
        hit_reg     <= in_hit;
        hit_idx_reg <= in_hit_idx;
    end

    assign out_valid   = valid_reg;
    assign out_key     = key_reg;
    assign out_pos     = pos_reg;
    assign out_hit     = hit_reg | (!hit_reg && rd_reg == key_reg && valid_reg);
    assign out_hit_idx = hit_reg ? hit_idx_reg : pos_reg;
endmodule

// ----- src/srcu_record_store.sv -----
// Record memory: one write port, one registered read port.
module srcu_record_store #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_idx,
    input  srcu_pkg::record_t      wr_data,
    input  logic [IDX_W-1:0]       rd_idx,
    output srcu_pkg::record_t      rd_data
);
    srcu_pkg::record_t mem [DEPTH];
    srcu_pkg::record_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_reg <= mem[rd_idx];
    end

    assign rd_data = rd_reg;
endmodule

// ----- src/spaced_repetition_card_update.sv -----
// Channel | Handshake         | Fields
// input   | s_valid / s_ready | s_cmd, s_card_hash, s_rating
// result  | m_valid / m_ready | m_status, m_new_ease, m_new_interval, m_due_session,
//         |                   | m_review_total, m_session_number
//
// A session item passes through the output state before its result is offered.
// A rating item probes the occupied entries one per cycle through a 4-cell chain (one
// cell when TABLE_ENTRIES is below 4); a hit ends the search early. Again, hard or a
// first review skip the second multiply and the divide.
// Reset (aresetn low, synchronous) empties the table and clears all counters.
// One item is in work at a time; s_ready stays low until its result has been taken.
`include "spaced_repetition_card_update_defines.svh"

module spaced_repetition_card_update #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_card_hash,
    input  logic [1:0]  s_rating,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_new_ease,
    output logic [15:0] m_new_interval,
    output logic [15:0] m_due_session,
    output logic [15:0] m_review_total,
    output logic [15:0] m_session_number
);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CELLS = (TABLE_ENTRIES >= 4) ? 4 : 1;
    localparam int SLICE = (TABLE_ENTRIES + CELLS - 1) / CELLS;

    srcu_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [31:0] tot_reviews_reg, tot_again_reg, tot_hard_reg;
    logic [31:0] tot_good_reg, tot_easy_reg, tot_lapses_reg;
    logic [15:0] ses_cur_reg, ses_total_reg, ses_last_reg;

    logic        cmd_reg;
    logic [31:0] key_reg;
    logic [1:0]  rating_reg;

    logic             found_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             is_new_reg;

    srcu_pkg::record_t rec_reg;
    logic [11:0] ease_reg;
    logic [31:0] prod_reg;
    logic [18:0] quot_reg;
    logic [18:0] ivl_reg;

    logic [1:0]  o_status_reg;
    logic [11:0] o_ease_reg;
    logic [15:0] o_ivl_reg, o_due_reg, o_rev_reg, o_ses_reg;
    logic        o_valid_reg;

    // Search chain wiring.
    logic              c_valid [CELLS+1];
    logic [31:0]       c_key   [CELLS+1];
    logic [IDX_W-1:0]  c_pos   [CELLS+1];
    logic              c_hit   [CELLS+1];
    logic [IDX_W-1:0]  c_hidx  [CELLS+1];

    logic [IDX_W-1:0] probe_reg;
    logic             probe_valid_reg;
    logic             key_wr_en;
    srcu_pkg::record_t rd_rec;
    srcu_pkg::record_t wr_rec;
    srcu_pkg::record_t fresh_rec;
    logic              rec_wr_en;

    // Combinational pieces of the rating rule.
    logic [11:0] base_ease, upd_ease;
    logic        first_rev;
    logic [16:0] ivl_plus;
    logic [18:0] ivl_min;
    logic [18:0] ivl_final;
    logic [15:0] ease_factor;
    logic [31:0] recip;
    logic [63:0] recip_prod;
    logic [18:0] quot_next;
    logic        tail_done;
    logic [19:0] due_full;
    logic [15:0] due_sat;
    logic        chain_done;

    assign c_valid[0] = probe_valid_reg;
    assign c_key[0]   = key_reg;
    assign c_pos[0]   = probe_reg;
    assign c_hit[0]   = 1'b0;
    assign c_hidx[0]  = '0;

    // Each probe position belongs to one cell; other cells pass it through
    // without a hit because their slice compare is masked by ownership.
    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            logic in_v;
            logic o_v;
            logic ov_reg;

            assign in_v = c_valid[g] &&
                (CNT_W'(c_pos[g]) >= CNT_W'(g * SLICE)) &&
                (CNT_W'(c_pos[g]) < CNT_W'((g + 1) * SLICE));

            srcu_key_cell #(.SLICE(SLICE), .IDX_W(IDX_W)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .in_valid   (in_v),
                .in_key     (c_key[g]),
                .in_pos     (c_pos[g]),
                .in_hit     (c_hit[g]),
                .in_hit_idx (c_hidx[g]),
                .wr_en      (key_wr_en && (CNT_W'(idx_reg) >= CNT_W'(g * SLICE)) &&
                             (CNT_W'(idx_reg) < CNT_W'((g + 1) * SLICE))),
                .wr_idx     (idx_reg),
                .wr_key     (key_reg),
                .base       (IDX_W'(g * SLICE)),
                .out_valid  (o_v),
                .out_key    (c_key[g+1]),
                .out_pos    (c_pos[g+1]),
                .out_hit    (c_hit[g+1]),
                .out_hit_idx(c_hidx[g+1])
            );

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    ov_reg <= 1'b0;
                end else begin
                    ov_reg <= c_valid[g];
                end
            end
            assign c_valid[g+1] = ov_reg | o_v;
        end
    endgenerate

    srcu_record_store #(.DEPTH(TABLE_ENTRIES), .IDX_W(IDX_W)) u_store (
        .aclk    (aclk),
        .wr_en   (rec_wr_en),
        .wr_idx  (idx_reg),
        .wr_data (wr_rec),
        .rd_idx  (idx_reg),
        .rd_data (rd_rec)
    );

    assign s_ready = (state_reg == srcu_pkg::ST_IDLE) && !o_valid_reg;
    assign m_valid = o_valid_reg;
    assign m_status = o_status_reg;
    assign m_new_ease = o_ease_reg;
    assign m_new_interval = o_ivl_reg;
    assign m_due_session = o_due_reg;
    assign m_review_total = o_rev_reg;
    assign m_session_number = o_ses_reg;

    assign base_ease = (rec_reg.ease == 12'd0) ? srcu_pkg::EASE_INIT : rec_reg.ease;
    assign first_rev = (rec_reg.reviews == 16'd0);
    assign ivl_plus  = {1'b0, rec_reg.interval} + 17'd1;

    always_comb begin
        case (rating_reg)
            srcu_pkg::RATE_AGAIN:
                upd_ease = (base_ease >= 12'd1500) ? base_ease - 12'd200 : srcu_pkg::EASE_MIN;
            srcu_pkg::RATE_HARD:
                upd_ease = (base_ease >= 12'd1400) ? base_ease - 12'd100 : srcu_pkg::EASE_MIN;
            srcu_pkg::RATE_GOOD:
                upd_ease = base_ease;
            default:
                upd_ease = (base_ease + 12'd150 > srcu_pkg::EASE_MAX) ?
                           srcu_pkg::EASE_MAX : base_ease + 12'd150;
        endcase
    end

    // Easy folds the factor 13 into the ease so one 16 by 16 product is enough.
    assign ease_factor = (rating_reg == srcu_pkg::RATE_EASY) ?
                         {4'd0, upd_ease} * 16'd13 : {4'd0, upd_ease};
    assign recip       = (rating_reg == srcu_pkg::RATE_EASY) ?
                         srcu_pkg::RECIP_10000 : srcu_pkg::RECIP_1000;
    assign recip_prod  = {32'd0, prod_reg} * {32'd0, recip};
    assign quot_next   = (rating_reg == srcu_pkg::RATE_EASY) ?
                         recip_prod[63:45] : recip_prod[56:38];
    assign ivl_min     = (rating_reg == srcu_pkg::RATE_EASY) ? 19'd4 : 19'd2;
    assign tail_done   = (rating_reg == srcu_pkg::RATE_AGAIN) ||
                         (rating_reg == srcu_pkg::RATE_HARD) || first_rev;

    always_comb begin
        if (rating_reg == srcu_pkg::RATE_AGAIN) begin
            ivl_final = 19'd1;
        end else if (rating_reg == srcu_pkg::RATE_HARD) begin
            ivl_final = {2'd0, ivl_plus};
        end else if (first_rev) begin
            ivl_final = ivl_min;
        end else if (quot_reg < ivl_min) begin
            ivl_final = ivl_min;
        end else begin
            ivl_final = quot_reg;
        end
    end

    // The due session uses the interval before it is saturated for storage.
    assign due_full = {4'd0, ses_cur_reg} + {1'b0, ivl_reg};
    assign due_sat  = (due_full > 20'd65535) ? 16'hFFFF : due_full[15:0];

    always_comb begin
        fresh_rec      = '0;
        fresh_rec.ease = srcu_pkg::EASE_INIT;
    end

    always_comb begin
        wr_rec           = rec_reg;
        wr_rec.ease      = ease_reg;
        wr_rec.interval  = (ivl_reg > 19'd65535) ? 16'hFFFF : ivl_reg[15:0];
        wr_rec.due       = due_sat;
        wr_rec.reviews   = srcu_pkg::sat_inc16(rec_reg.reviews);
        wr_rec.last_seen = {ses_cur_reg, rating_reg};
        case (rating_reg)
            srcu_pkg::RATE_AGAIN: begin
                wr_rec.lapses = srcu_pkg::sat_inc16(rec_reg.lapses);
                wr_rec.again  = srcu_pkg::sat_inc16(rec_reg.again);
            end
            srcu_pkg::RATE_HARD: wr_rec.hard = srcu_pkg::sat_inc16(rec_reg.hard);
            srcu_pkg::RATE_GOOD: wr_rec.good = srcu_pkg::sat_inc16(rec_reg.good);
            default:             wr_rec.easy = srcu_pkg::sat_inc16(rec_reg.easy);
        endcase
    end

    assign chain_done = c_valid[CELLS] && (CNT_W'(c_pos[CELLS]) + CNT_W'(1) >= count_reg);

    always_comb begin
        state_next = state_reg;
        key_wr_en  = 1'b0;
        rec_wr_en  = 1'b0;
        case (state_reg)
            srcu_pkg::ST_IDLE: begin
                if (s_valid && !o_valid_reg) begin
                    state_next = s_cmd ? srcu_pkg::ST_SEARCH : srcu_pkg::ST_OUT;
                end
            end
            srcu_pkg::ST_SEARCH: begin
                if (found_reg || (count_reg == '0) ||
                    (!probe_valid_reg && chain_done)) begin
                    state_next = srcu_pkg::ST_READ;
                end
            end
            srcu_pkg::ST_READ: begin
                if (!found_reg && count_reg >= CNT_W'(TABLE_ENTRIES)) begin
                    state_next = srcu_pkg::ST_OUT;
                end else begin
                    key_wr_en  = !found_reg;
                    state_next = srcu_pkg::ST_READ_WAIT;
                end
            end
            srcu_pkg::ST_READ_WAIT: state_next = srcu_pkg::ST_MUL1;
            srcu_pkg::ST_MUL1: state_next = tail_done ? srcu_pkg::ST_WRITE : srcu_pkg::ST_MUL2;
            srcu_pkg::ST_MUL2: state_next = srcu_pkg::ST_DIV;
            srcu_pkg::ST_DIV: state_next = srcu_pkg::ST_WRITE;
            srcu_pkg::ST_WRITE: begin
                rec_wr_en  = 1'b1;
                state_next = srcu_pkg::ST_OUT;
            end
            srcu_pkg::ST_OUT: state_next = srcu_pkg::ST_IDLE;
            default: state_next = srcu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srcu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            tot_reviews_reg <= '0;
            tot_again_reg   <= '0;
            tot_hard_reg    <= '0;
            tot_good_reg    <= '0;
            tot_easy_reg    <= '0;
            tot_lapses_reg  <= '0;
            ses_cur_reg     <= '0;
            ses_total_reg   <= '0;
            ses_last_reg    <= '0;
            o_valid_reg     <= 1'b0;
            probe_valid_reg <= 1'b0;
            found_reg       <= 1'b0;
        end else begin
            if (state_reg == srcu_pkg::ST_OUT) begin
                o_valid_reg <= 1'b1;
            end else if (o_valid_reg && m_ready) begin
                o_valid_reg <= 1'b0;
            end
            case (state_reg)
                srcu_pkg::ST_IDLE: begin
                    if (s_valid && !o_valid_reg) begin
                        cmd_reg    <= s_cmd;
                        key_reg    <= s_card_hash;
                        rating_reg <= s_rating;
                        probe_reg  <= '0;
                        found_reg  <= 1'b0;
                        is_new_reg <= 1'b0;
                        probe_valid_reg <= s_cmd && (count_reg != '0);
                    end
                end
                srcu_pkg::ST_SEARCH: begin
                    if (c_valid[CELLS] && c_hit[CELLS] && !found_reg) begin
                        found_reg <= 1'b1;
                        idx_reg   <= c_hidx[CELLS];
                        probe_valid_reg <= 1'b0;
                    end else begin
                        if (!found_reg) begin
                            idx_reg <= IDX_W'(count_reg);
                        end
                        if (probe_valid_reg) begin
                            if (CNT_W'(probe_reg) + CNT_W'(1) >= count_reg) begin
                                probe_valid_reg <= 1'b0;
                            end else begin
                                probe_reg <= probe_reg + IDX_W'(1);
                            end
                        end
                    end
                end
                srcu_pkg::ST_READ: begin
                    if (!found_reg && count_reg < CNT_W'(TABLE_ENTRIES)) begin
                        count_reg  <= count_reg + CNT_W'(1);
                        is_new_reg <= 1'b1;
                    end
                end
                srcu_pkg::ST_WRITE: begin
                    ses_last_reg    <= ses_cur_reg;
                    tot_reviews_reg <= srcu_pkg::sat_inc32(tot_reviews_reg);
                    case (rating_reg)
                        srcu_pkg::RATE_AGAIN: begin
                            tot_again_reg  <= srcu_pkg::sat_inc32(tot_again_reg);
                            tot_lapses_reg <= srcu_pkg::sat_inc32(tot_lapses_reg);
                        end
                        srcu_pkg::RATE_HARD: tot_hard_reg <= srcu_pkg::sat_inc32(tot_hard_reg);
                        srcu_pkg::RATE_GOOD: tot_good_reg <= srcu_pkg::sat_inc32(tot_good_reg);
                        default:             tot_easy_reg <= srcu_pkg::sat_inc32(tot_easy_reg);
                    endcase
                end
                srcu_pkg::ST_OUT: begin
                    if (!cmd_reg) begin
                        ses_cur_reg   <= srcu_pkg::sat_inc16(ses_cur_reg);
                        ses_total_reg <= srcu_pkg::sat_inc16(ses_total_reg);
                        o_status_reg  <= srcu_pkg::STATUS_SESSION;
                        o_ses_reg     <= srcu_pkg::sat_inc16(ses_cur_reg);
                        o_ease_reg    <= '0;
                        o_ivl_reg     <= '0;
                        o_due_reg     <= '0;
                        o_rev_reg     <= '0;
                    end else if (!found_reg && !is_new_reg) begin
                        o_status_reg <= srcu_pkg::STATUS_FULL;
                        o_ses_reg    <= ses_cur_reg;
                        o_ease_reg   <= '0;
                        o_ivl_reg    <= '0;
                        o_due_reg    <= '0;
                        o_rev_reg    <= '0;
                    end else begin
                        o_status_reg <= srcu_pkg::STATUS_RATED;
                        o_ses_reg    <= ses_cur_reg;
                        o_ease_reg   <= wr_rec.ease;
                        o_ivl_reg    <= wr_rec.interval;
                        o_due_reg    <= wr_rec.due;
                        o_rev_reg    <= wr_rec.reviews;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset. The record read issued in the read
    // state appears on the registered read port in the wait state, where it is captured.
    always_ff @(posedge aclk) begin
        if (state_reg == srcu_pkg::ST_READ_WAIT) begin
            rec_reg <= is_new_reg ? fresh_rec : rd_rec;
        end
        if (state_reg == srcu_pkg::ST_MUL1) begin
            ease_reg <= upd_ease;
            prod_reg <= {16'd0, rec_reg.interval} * {16'd0, ease_factor};
        end
        if (state_reg == srcu_pkg::ST_MUL2) begin
            quot_reg <= quot_next;
        end
        if (state_reg == srcu_pkg::ST_DIV || state_reg == srcu_pkg::ST_MUL1) begin
            ivl_reg <= ivl_final;
        end
    end

    `SRCU_ASSERT_IMPL(a_ready_idle, aclk, aresetn,
        s_ready, state_reg == srcu_pkg::ST_IDLE)
    `SRCU_ASSERT_IMPL(a_ready_no_result, aclk, aresetn,
        s_ready, !m_valid)
    `SRCU_ASSERT_IMPL(a_count_max, aclk, aresetn,
        1'b1, count_reg <= CNT_W'(TABLE_ENTRIES))
    `SRCU_ASSERT_NEXT(a_out_after, aclk, aresetn,
        state_reg == srcu_pkg::ST_OUT, m_valid)
endmodule
